[rtl/trapezoid_motion_profile_macros.svh]
// Assertion macros shared by the trapezoid motion profile RTL.
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TMP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define TMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/tmp_pkg.sv]
// Shared types and constants of the trapezoid motion profile block.
package tmp_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [CFG_ADDR_W-3:0] REG_START_POS    = 3'd0;
  localparam logic [CFG_ADDR_W-3:0] REG_END_POS      = 3'd1;
  localparam logic [CFG_ADDR_W-3:0] REG_PEAK_VEL     = 3'd2;
  localparam logic [CFG_ADDR_W-3:0] REG_ACCEL        = 3'd3;
  localparam logic [CFG_ADDR_W-3:0] REG_ACCEL_TICKS  = 3'd4;
  localparam logic [CFG_ADDR_W-3:0] REG_CRUISE_TICKS = 3'd5;

  // unsigned product width; products saturate at 2^61
  localparam int PROD_W = 63;
  localparam logic [PROD_W-1:0] PROD_CAP = {2'b01, {(PROD_W-2){1'b0}}};

  // signed width of position and velocity sums before saturation
  localparam int SUM_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_AX,   // a * x
    OP_AXX,  // (a * x) * x
    OP_AA,   // a * A
    OP_AAA,  // (a * A) * A
    OP_VT    // v * (t - A)
  } op_t;

  typedef enum logic [1:0] {
    PH_UP,
    PH_CRUISE,
    PH_DOWN
  } phase_t;

  typedef struct packed {
    logic moving_up;
    logic halted;
  } status_t;

endpackage

[rtl/tmp_if.sv]
// Valid/ready channel interfaces for tick input and profile results.
interface tmp_in_if;
  logic valid;
  logic ready;
  logic obstacle_detected;

  modport source (output valid, output obstacle_detected, input ready);
  modport sink   (input valid, input obstacle_detected, output ready);
endinterface

interface tmp_out_if #(
  parameter int POSITION_WIDTH = 32
);
  logic                             valid;
  logic                             ready;
  logic signed [POSITION_WIDTH-1:0] ref_position;
  logic signed [31:0]               ref_velocity;
  logic signed [31:0]               ref_acceleration;
  logic                             moving_up_out;
  logic                             halted_out;

  modport source (output valid, output ref_position, output ref_velocity,
                  output ref_acceleration, output moving_up_out, output halted_out,
                  input ready);
  modport sink   (input valid, input ref_position, input ref_velocity,
                  input ref_acceleration, input moving_up_out, input halted_out,
                  output ready);
endinterface

[rtl/tmp_serial_mul.sv]
// Bit-serial saturating multiplier, one multiplier bit per cycle, MSB first.
module tmp_serial_mul #(
  parameter int XW = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tmp_pkg::PROD_W-1:0] mcand,
  input  logic [XW-1:0]             mplier,
  output logic                      busy,
  output logic [tmp_pkg::PROD_W-1:0] prod
);
  import tmp_pkg::*;

  localparam int CNT_W = $clog2(XW + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [XW-1:0]     sh_r, sh_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] addend;
  logic [PROD_W:0]   step_sum;

  // Horner step: acc = min(2*acc + bit*mcand, cap); exact min() since steps are monotone
  always_comb begin
    addend   = sh_r[XW-1] ? mcand : {PROD_W{1'b0}};
    step_sum = {acc_r, 1'b0} + {1'b0, addend};
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    if (start) begin
      cnt_nxt = CNT_W'(XW);
      sh_nxt  = mplier;
      acc_nxt = {PROD_W{1'b0}};
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      sh_nxt  = {sh_r[XW-2:0], 1'b0};
      acc_nxt = (step_sum > {1'b0, PROD_CAP}) ? PROD_CAP : step_sum[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = (cnt_r != '0);
  assign prod = acc_r;

endmodule

[rtl/tmp_cfg_regs.sv]
// APB-style configuration register file of the motion profile.
module tmp_cfg_regs #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tmp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tmp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic signed [31:0]            start_pos,
  output logic signed [31:0]            end_pos,
  output logic [30:0]                   peak_vel,
  output logic [30:0]                   accel,
  output logic [TICK_WIDTH-1:0]         accel_ticks,
  output logic [TICK_WIDTH-1:0]         cruise_ticks
);
  import tmp_pkg::*;

  logic [CFG_ADDR_W-3:0] idx;
  logic                  wr_en;

  logic signed [31:0]    start_pos_r, start_pos_nxt;
  logic signed [31:0]    end_pos_r, end_pos_nxt;
  logic [30:0]           peak_vel_r, peak_vel_nxt;
  logic [30:0]           accel_r, accel_nxt;
  logic [TICK_WIDTH-1:0] accel_ticks_r, accel_ticks_nxt;
  logic [TICK_WIDTH-1:0] cruise_ticks_r, cruise_ticks_nxt;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    start_pos_nxt    = start_pos_r;
    end_pos_nxt      = end_pos_r;
    peak_vel_nxt     = peak_vel_r;
    accel_nxt        = accel_r;
    accel_ticks_nxt  = accel_ticks_r;
    cruise_ticks_nxt = cruise_ticks_r;
    if (wr_en) begin
      unique case (idx)
        REG_START_POS:    start_pos_nxt    = pwdata;
        REG_END_POS:      end_pos_nxt      = pwdata;
        REG_PEAK_VEL:     peak_vel_nxt     = pwdata[30:0];
        REG_ACCEL:        accel_nxt        = pwdata[30:0];
        REG_ACCEL_TICKS:  accel_ticks_nxt  = pwdata[TICK_WIDTH-1:0];
        REG_CRUISE_TICKS: cruise_ticks_nxt = pwdata[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_POS:    prdata = start_pos_r;
      REG_END_POS:      prdata = end_pos_r;
      REG_PEAK_VEL:     prdata = {1'b0, peak_vel_r};
      REG_ACCEL:        prdata = {1'b0, accel_r};
      REG_ACCEL_TICKS:  prdata = {{(CFG_DATA_W-TICK_WIDTH){1'b0}}, accel_ticks_r};
      REG_CRUISE_TICKS: prdata = {{(CFG_DATA_W-TICK_WIDTH){1'b0}}, cruise_ticks_r};
      default:          prdata = {CFG_DATA_W{1'b0}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r    <= '0;
      end_pos_r      <= '0;
      peak_vel_r     <= '0;
      accel_r        <= '0;
      accel_ticks_r  <= TICK_WIDTH'(1);
      cruise_ticks_r <= '0;
    end else begin
      start_pos_r    <= start_pos_nxt;
      end_pos_r      <= end_pos_nxt;
      peak_vel_r     <= peak_vel_nxt;
      accel_r        <= accel_nxt;
      accel_ticks_r  <= accel_ticks_nxt;
      cruise_ticks_r <= cruise_ticks_nxt;
    end
  end

  assign start_pos    = start_pos_r;
  assign end_pos      = end_pos_r;
  assign peak_vel     = peak_vel_r;
  assign accel        = accel_r;
  assign accel_ticks  = accel_ticks_r;
  assign cruise_ticks = cruise_ticks_r;

endmodule

[rtl/tmp_profile_core.sv]
// Per-tick profile sequencer: phase decode, serial products, sums, saturation.
module tmp_profile_core #(
  parameter int POSITION_WIDTH = 32,
  parameter int TICK_WIDTH     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             obstacle,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic signed [POSITION_WIDTH-1:0] res_position,
  output logic signed [31:0]               res_velocity,
  output logic signed [31:0]               res_acceleration,
  output tmp_pkg::status_t                 res_status,
  input  logic signed [31:0]               start_pos,
  input  logic signed [31:0]               end_pos,
  input  logic [30:0]                      peak_vel,
  input  logic [30:0]                      accel,
  input  logic [TICK_WIDTH-1:0]            accel_ticks,
  input  logic [TICK_WIDTH-1:0]            cruise_ticks
);
  import tmp_pkg::*;

  localparam int XW = TICK_WIDTH + 2;
  localparam int PW = POSITION_WIDTH;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  phase_t phase_r, phase_nxt;

  logic [XW-1:0] elapsed_r, elapsed_nxt;
  logic [XW-1:0] t_r, t_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [XW-1:0] ta_r, ta_nxt;
  logic          done_r, done_nxt;
  logic          moving_up_r, moving_up_nxt;
  logic          halted_r, halted_nxt;

  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [PROD_W-1:0]       axv_r, axv_nxt;
  logic signed [SUM_W-1:0] dsum_r, dsum_nxt;
  logic signed [SUM_W-1:0] pos_raw_r, pos_raw_nxt;
  logic signed [SUM_W-1:0] vel_raw_r, vel_raw_nxt;
  logic signed [PW-1:0]    pos_r, pos_nxt;
  logic signed [31:0]      vel_r, vel_nxt;
  logic signed [31:0]      acc_r, acc_nxt;

  // phase decode
  logic [XW-1:0] a_ext, c_ext, apc, tot;
  logic          sw_up, sw_cruise;

  // multiplier
  logic              mul_start, mul_busy, op_last;
  logic [PROD_W-1:0] mul_mcand, mul_prod, accel_ext;
  logic [XW-1:0]     mul_mplier;

  // finishing sums
  logic signed [SUM_W-1:0] half_s, full_s, axv_s, pv_s, vel_p, vel_q;
  logic signed [SUM_W-1:0] q0_s, dest_s;
  logic signed [31:0]      acc_mag;
  logic                    acc_neg;
  logic [SUM_W-PW:0]       pos_top;
  logic [SUM_W-32:0]       vel_top;
  logic signed [PW-1:0]    pos_sat;
  logic signed [31:0]      vel_sat;

  assign a_ext     = XW'(accel_ticks);
  assign c_ext     = XW'(cruise_ticks);
  assign apc       = a_ext + c_ext;
  assign tot       = apc + a_ext;
  assign sw_up     = (t_r <= a_ext);
  assign sw_cruise = (t_r <= apc);
  assign accel_ext = {{(PROD_W-31){1'b0}}, accel};

  assign op_last = (op_r == OP_VT) || ((op_r == OP_AXX) && (phase_r == PH_UP));

  always_comb begin
    case (op_r)
      OP_AX:   begin mul_mcand = accel_ext; mul_mplier = x_r;  end
      OP_AXX:  begin mul_mcand = prod_r;    mul_mplier = x_r;  end
      OP_AA:   begin mul_mcand = accel_ext; mul_mplier = a_ext; end
      OP_AAA:  begin mul_mcand = prod_r;    mul_mplier = a_ext; end
      OP_VT:   begin mul_mcand = {{(PROD_W-31){1'b0}}, peak_vel}; mul_mplier = ta_r; end
      default: begin mul_mcand = accel_ext; mul_mplier = x_r;  end
    endcase
  end

  tmp_serial_mul #(
    .XW (XW)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .busy   (mul_busy),
    .prod   (mul_prod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = (halted_r || obstacle) ? ST_DONE : ST_SETUP;
      ST_SETUP: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   if (!mul_busy) state_nxt = op_last ? ST_FIN : ST_LOAD;
      ST_FIN:   state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_DONE;
      ST_DONE:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    mul_start = (state_r == ST_LOAD);
  end

  // finishing operands
  always_comb begin
    half_s = $signed({{(SUM_W-PROD_W+1){1'b0}}, mul_prod[PROD_W-1:1]});
    full_s = $signed({{(SUM_W-PROD_W){1'b0}}, mul_prod});
    axv_s  = $signed({{(SUM_W-PROD_W){1'b0}}, axv_r});
    pv_s   = $signed({{(SUM_W-31){1'b0}}, peak_vel});
    q0_s   = moving_up_r ? SUM_W'(start_pos) : SUM_W'(end_pos);
    dest_s = moving_up_r ? SUM_W'(end_pos) : SUM_W'(start_pos);
    // velocity = p - q with the direction folded in
    case (phase_r)
      PH_UP: begin
        vel_p = moving_up_r ? axv_s : '0;
        vel_q = moving_up_r ? '0 : axv_s;
      end
      PH_CRUISE: begin
        vel_p = moving_up_r ? pv_s : '0;
        vel_q = moving_up_r ? '0 : pv_s;
      end
      default: begin
        vel_p = moving_up_r ? pv_s : axv_s;
        vel_q = moving_up_r ? axv_s : pv_s;
      end
    endcase
    acc_mag = (phase_r == PH_CRUISE) ? 32'sd0 : $signed({1'b0, accel});
    acc_neg = (phase_r == PH_DOWN) ? moving_up_r : !moving_up_r;

    pos_top = pos_raw_r[SUM_W-1:PW-1];
    if ((&pos_top) || !(|pos_top)) begin
      pos_sat = pos_raw_r[PW-1:0];
    end else begin
      pos_sat = pos_raw_r[SUM_W-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end
    vel_top = vel_raw_r[SUM_W-1:31];
    if ((&vel_top) || !(|vel_top)) begin
      vel_sat = vel_raw_r[31:0];
    end else begin
      vel_sat = vel_raw_r[SUM_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
  end

  // datapath next values
  always_comb begin
    t_nxt         = t_r;
    x_nxt         = x_r;
    ta_nxt        = ta_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    done_nxt      = done_r;
    prod_nxt      = prod_r;
    axv_nxt       = axv_r;
    dsum_nxt      = dsum_r;
    pos_raw_nxt   = pos_raw_r;
    vel_raw_nxt   = vel_raw_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    acc_nxt       = acc_r;
    elapsed_nxt   = elapsed_r;
    moving_up_nxt = moving_up_r;
    halted_nxt    = halted_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (halted_r || obstacle) halted_nxt = 1'b1;
          t_nxt = elapsed_r + XW'(1);
        end
      end
      ST_SETUP: begin
        phase_nxt = sw_up ? PH_UP : (sw_cruise ? PH_CRUISE : PH_DOWN);
        x_nxt     = sw_up ? t_r : (t_r - apc);
        ta_nxt    = t_r - a_ext;
        done_nxt  = !sw_cruise && (t_r >= tot);
        op_nxt    = (!sw_up && sw_cruise) ? OP_AA : OP_AX;
        dsum_nxt  = '0;
      end
      ST_MUL: begin
        if (!mul_busy) begin
          case (op_r)
            OP_AX: begin
              prod_nxt = mul_prod;
              axv_nxt  = mul_prod;
              op_nxt   = OP_AXX;
            end
            OP_AXX: begin
              dsum_nxt = (phase_r == PH_UP) ? (dsum_r + half_s) : (dsum_r - half_s);
              op_nxt   = OP_AA;
            end
            OP_AA: begin
              prod_nxt = mul_prod;
              op_nxt   = OP_AAA;
            end
            OP_AAA: begin
              dsum_nxt = dsum_r + half_s;
              op_nxt   = OP_VT;
            end
            default: dsum_nxt = dsum_r + full_s;
          endcase
        end
      end
      ST_FIN: begin
        if (done_r) begin
          pos_raw_nxt = dest_s;
        end else begin
          pos_raw_nxt = moving_up_r ? (q0_s + dsum_r) : (q0_s - dsum_r);
        end
        vel_raw_nxt = vel_p - vel_q;
      end
      ST_SAT: begin
        pos_nxt = pos_sat;
        vel_nxt = vel_sat;
        acc_nxt = acc_neg ? -acc_mag : acc_mag;
        if (done_r) begin
          elapsed_nxt   = '0;
          moving_up_nxt = !moving_up_r;
        end else begin
          elapsed_nxt = t_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      moving_up_r <= 1'b1;
      halted_r    <= 1'b0;
      pos_r       <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      moving_up_r <= moving_up_nxt;
      halted_r    <= halted_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      acc_r       <= acc_nxt;
    end
    op_r      <= op_nxt;
    phase_r   <= phase_nxt;
    t_r       <= t_nxt;
    x_r       <= x_nxt;
    ta_r      <= ta_nxt;
    done_r    <= done_nxt;
    prod_r    <= prod_nxt;
    axv_r     <= axv_nxt;
    dsum_r    <= dsum_nxt;
    pos_raw_r <= pos_raw_nxt;
    vel_raw_r <= vel_raw_nxt;
  end

  assign res_position         = pos_r;
  assign res_velocity         = vel_r;
  assign res_acceleration     = acc_r;
  assign res_status.moving_up = moving_up_r;
  assign res_status.halted    = halted_r;

endmodule

[rtl/trapezoid_motion_profile.sv]
// Top level of the trapezoidal velocity profile generator.
//
// Usage: each transaction on in_ch is one control tick with an obstacle flag.
// Every tick yields exactly one transaction on out_ch with the reference
// position (Q16.16, saturated to POSITION_WIDTH), velocity and acceleration,
// the sweep direction and the halted flag. The user must write registers
// over the APB-style port (byte address 4*index) only while no tick is
// in flight; the block itself does not enforce this. Each tick runs N
// serial products per phase: 2 in ramp up, 3 in cruise, 5 in ramp down.
// The bit-serial multiplier takes one multiplier bit per cycle. A halted
// or obstacle tick skips the products. The result reaches out_ch via the
// output register, which loads it once the register is free.
// Throughput: one tick in flight at a time; a new tick is taken while the
// previous result still waits in the output register.
// Reset (synchronous, rst_n low): registers return to defaults, direction
// points to end_position, counter and held outputs clear, no result pending.
// Receiver stall: the output register holds its transaction; the core
// finishes the next tick and then waits until the register frees.
`include "trapezoid_motion_profile_macros.svh"

module trapezoid_motion_profile #(
  parameter int POSITION_WIDTH = 32,
  parameter int TICK_WIDTH     = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tmp_in_if.sink                         in_ch,
  tmp_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tmp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tmp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tmp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tmp_pkg::*;

  // configuration
  logic signed [31:0]    start_pos, end_pos;
  logic [30:0]           peak_vel, accel;
  logic [TICK_WIDTH-1:0] accel_ticks, cruise_ticks;

  // core result side
  logic                             core_in_ready;
  logic                             core_res_valid;
  logic                             core_res_ready;
  logic signed [POSITION_WIDTH-1:0] core_pos;
  logic signed [31:0]               core_vel, core_acc;
  status_t                          core_status;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic signed [POSITION_WIDTH-1:0] out_pos_r, out_pos_nxt;
  logic signed [31:0]               out_vel_r, out_vel_nxt;
  logic signed [31:0]               out_acc_r, out_acc_nxt;
  status_t                          out_status_r, out_status_nxt;
  logic                             load;

  tmp_cfg_regs #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_pos    (start_pos),
    .end_pos      (end_pos),
    .peak_vel     (peak_vel),
    .accel        (accel),
    .accel_ticks  (accel_ticks),
    .cruise_ticks (cruise_ticks)
  );

  tmp_profile_core #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TICK_WIDTH     (TICK_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (core_in_ready),
    .obstacle         (in_ch.obstacle_detected),
    .res_valid        (core_res_valid),
    .res_ready        (core_res_ready),
    .res_position     (core_pos),
    .res_velocity     (core_vel),
    .res_acceleration (core_acc),
    .res_status       (core_status),
    .start_pos        (start_pos),
    .end_pos          (end_pos),
    .peak_vel         (peak_vel),
    .accel            (accel),
    .accel_ticks      (accel_ticks),
    .cruise_ticks     (cruise_ticks)
  );

  assign in_ch.ready = core_in_ready;

  // output slot is free when empty or being drained this cycle
  assign core_res_ready = !out_valid_r || out_ch.ready;
  assign load           = core_res_valid && core_res_ready;

  always_comb begin
    out_pos_nxt    = out_pos_r;
    out_vel_nxt    = out_vel_r;
    out_acc_nxt    = out_acc_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;
    if (load) begin
      out_pos_nxt    = core_pos;
      out_vel_nxt    = core_vel;
      out_acc_nxt    = core_acc;
      out_status_nxt = core_status;
      out_valid_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_pos_r    <= out_pos_nxt;
    out_vel_r    <= out_vel_nxt;
    out_acc_r    <= out_acc_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.ref_position     = out_pos_r;
  assign out_ch.ref_velocity     = out_vel_r;
  assign out_ch.ref_acceleration = out_acc_r;
  assign out_ch.moving_up_out    = out_status_r.moving_up;
  assign out_ch.halted_out       = out_status_r.halted;

  // halted only clears by reset
  `TMP_ASSERT_NEXT(a_halt_sticky, clk, rst_n, core_status.halted, core_status.halted, "halted flag cleared")
  // once halted the sweep direction is frozen
  `TMP_ASSERT_NEXT(a_halt_dir_frozen, clk, rst_n, core_status.halted, $stable(core_status.moving_up), "direction changed while halted")
  // no new tick while the core still holds an undelivered result
  `TMP_ASSERT_SAME(a_no_accept_pending, clk, rst_n, core_res_valid, !(in_ch.valid && in_ch.ready), "tick accepted while a result is pending")

endmodule
